// ----- rtl/bounded_pifo_rank_queue_defines.svh -----
// Assertion macros for the bounded PIFO rank queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BOUNDED_PIFO_RANK_QUEUE_DEFINES_SVH
`define BOUNDED_PIFO_RANK_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPRQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bprq_pkg.sv -----
// Shared types and codes for the bounded PIFO rank queue.
// No dependencies.
package bprq_pkg;

  localparam int ACT_W    = 2;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 5;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POP_HEAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_TAIL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // Register index, taken from paddr[ADDR_W-1]
  localparam logic REG_HIGH_LIMIT = 1'b0;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd20;

  // Per-transfer controls broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop_head;
  } bprq_ctl_t;

endpackage

// ----- rtl/bprq_cell.sv -----
// One storage cell of the PIFO shift chain: holds an (item, rank) entry.
// Depends on bprq_pkg for the control struct.
module bprq_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 6,
  parameter int RANK_BITS = 16,
  parameter int ITEM_BITS = 16
) (
  input  logic                  clk,
  input  bprq_pkg::bprq_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [RANK_BITS-1:0]  new_rank,
  input  logic [ITEM_BITS-1:0]  new_item,
  input  logic                  prev_ins,
  input  logic [RANK_BITS-1:0]  prev_rank,
  input  logic [ITEM_BITS-1:0]  prev_item,
  input  logic [RANK_BITS-1:0]  next_rank,
  input  logic [ITEM_BITS-1:0]  next_item,
  output logic                  ins,
  output logic [RANK_BITS-1:0]  rank,
  output logic [ITEM_BITS-1:0]  item,
  output logic [RANK_BITS-1:0]  tail_rank,
  output logic [ITEM_BITS-1:0]  tail_item
);

  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  logic [ITEM_BITS-1:0] item_r, item_nxt;
  logic                 occupied;
  logic                 is_tail;

  assign occupied = count > CNT_W'(IDX);
  assign is_tail  = count == CNT_W'(IDX + 1);

  // At or past the insertion point: a free cell, or a stored rank not below the new one
  assign ins = !occupied || (rank_r >= new_rank);

  always_comb begin
    rank_nxt = rank_r;
    item_nxt = item_r;
    if (ctl.push) begin
      if (prev_ins) begin
        rank_nxt = prev_rank;
        item_nxt = prev_item;
      end else if (ins) begin
        rank_nxt = new_rank;
        item_nxt = new_item;
      end
    end else if (ctl.pop_head) begin
      rank_nxt = next_rank;
      item_nxt = next_item;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    item_r <= item_nxt;
  end

  assign rank      = rank_r;
  assign item      = item_r;
  assign tail_rank = is_tail ? rank_r : '0;
  assign tail_item = is_tail ? item_r : '0;

endmodule

// ----- rtl/bounded_pifo_rank_queue.sv -----
// Bounded PIFO rank queue: a chain of DEPTH cells kept sorted by ascending rank.
// An accepted item's result is offered in the cycle after the transfer. Throughput: one
// item per cycle unless stalled; a new item enters while the previous result is taken,
// since all cells compare against the new rank in parallel and shift together.
// Reset clears the fill, the output valid and sets high_limit to 20; cell contents
// are not cleared. Depends on bprq_pkg, bprq_cell and the defines header.
`include "bounded_pifo_rank_queue_defines.svh"

module bounded_pifo_rank_queue #(
  parameter int DEPTH     = 32,
  parameter int RANK_BITS = 16,
  parameter int ITEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bprq_pkg::ACT_W-1:0]          in_action,
  input  logic [ITEM_BITS-1:0]                in_item_id,
  input  logic [RANK_BITS-1:0]                in_rank,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bprq_pkg::STATUS_W-1:0]       out_status,
  output logic [ITEM_BITS-1:0]                out_item,
  output logic [RANK_BITS-1:0]                out_rank,
  output logic [$clog2(DEPTH+1)-1:0]          out_fill,
  output logic [RANK_BITS-1:0]                out_max_rank,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bprq_pkg::ADDR_W-1:0]         paddr,
  input  logic [bprq_pkg::DATA_W-1:0]         pwdata,
  output logic [bprq_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W + 1 > bprq_pkg::LIMIT_W) ? CNT_W + 1 : bprq_pkg::LIMIT_W;

  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           out_valid_r;
  logic [bprq_pkg::LIMIT_W-1:0]   high_limit_r;
  logic [bprq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [ITEM_BITS-1:0]           oitem_r, oitem_nxt;
  logic [RANK_BITS-1:0]           orank_r, orank_nxt;

  logic                           accept;
  logic                           cfg_write;
  logic                           empty;
  logic                           evict;
  logic                           evict_new;
  logic [CMP_W-1:0]               grow;
  bprq_pkg::bprq_ctl_t            ctl;

  logic                           ins_chain  [DEPTH+1];
  logic [RANK_BITS-1:0]           rank_chain [DEPTH+1];
  logic [ITEM_BITS-1:0]           item_chain [DEPTH+1];
  logic [RANK_BITS-1:0]           tail_rank_w [DEPTH];
  logic [ITEM_BITS-1:0]           tail_item_w [DEPTH];
  logic [RANK_BITS-1:0]           tail_rank;
  logic [ITEM_BITS-1:0]           tail_item;

  // Handshakes
  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[bprq_pkg::ADDR_W-1] == bprq_pkg::REG_HIGH_LIMIT) begin
      prdata = bprq_pkg::DATA_W'(high_limit_r);
    end
  end

  // Cell chain
  assign ins_chain[0]  = 1'b0;
  assign rank_chain[0] = '0;
  assign item_chain[0] = '0;

  assign ctl.push     = accept && (in_action == bprq_pkg::ACT_PUSH);
  assign ctl.pop_head = accept && (in_action == bprq_pkg::ACT_POP_HEAD) && !empty;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [RANK_BITS-1:0] nx_rank;
    logic [ITEM_BITS-1:0] nx_item;

    if (g == DEPTH - 1) begin : g_last
      // Last cell holds on a head pop
      assign nx_rank = rank_chain[g+1];
      assign nx_item = item_chain[g+1];
    end else begin : g_mid
      assign nx_rank = rank_chain[g+2];
      assign nx_item = item_chain[g+2];
    end

    bprq_cell #(
      .IDX       (g),
      .CNT_W     (CNT_W),
      .RANK_BITS (RANK_BITS),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .new_rank  (in_rank),
      .new_item  (in_item_id),
      .prev_ins  (ins_chain[g]),
      .prev_rank (rank_chain[g]),
      .prev_item (item_chain[g]),
      .next_rank (nx_rank),
      .next_item (nx_item),
      .ins       (ins_chain[g+1]),
      .rank      (rank_chain[g+1]),
      .item      (item_chain[g+1]),
      .tail_rank (tail_rank_w[g]),
      .tail_item (tail_item_w[g])
    );
  end

  // Only the tail cell drives a nonzero value
  always_comb begin
    tail_rank = '0;
    tail_item = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_rank = tail_rank | tail_rank_w[i];
      tail_item = tail_item | tail_item_w[i];
    end
  end

  // Step control
  assign empty     = count_r == '0;
  assign grow      = CMP_W'(count_r) + CMP_W'(1);
  assign evict     = (grow > CMP_W'(high_limit_r)) || (count_r == CNT_W'(DEPTH));
  // The new entry lands at the tail when no stored rank reaches it
  assign evict_new = empty || (tail_rank < in_rank);

  always_comb begin
    status_nxt = bprq_pkg::ST_NONE;
    oitem_nxt  = '0;
    orank_nxt  = '0;
    count_nxt  = count_r;
    case (in_action)
      bprq_pkg::ACT_PUSH: begin
        if (evict) begin
          status_nxt = bprq_pkg::ST_EVICT;
          oitem_nxt  = evict_new ? in_item_id : tail_item;
          orank_nxt  = evict_new ? in_rank : tail_rank;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bprq_pkg::ACT_POP_HEAD: begin
        if (empty) begin
          status_nxt = bprq_pkg::ST_EMPTY;
        end else begin
          status_nxt = bprq_pkg::ST_POP_HEAD;
          oitem_nxt  = item_chain[1];
          orank_nxt  = rank_chain[1];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      bprq_pkg::ACT_POP_TAIL: begin
        if (empty) begin
          status_nxt = bprq_pkg::ST_EMPTY;
        end else begin
          status_nxt = bprq_pkg::ST_POP_TAIL;
          oitem_nxt  = tail_item;
          orank_nxt  = tail_rank;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = bprq_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      high_limit_r <= bprq_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write && (paddr[bprq_pkg::ADDR_W-1] == bprq_pkg::REG_HIGH_LIMIT)) begin
        high_limit_r <= pwdata[bprq_pkg::LIMIT_W-1:0];
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      oitem_r  <= oitem_nxt;
      orank_r  <= orank_nxt;
    end
  end

  // Fill and tail rank follow the cells, which hold while the result waits
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_item     = oitem_r;
  assign out_rank     = orank_r;
  assign out_fill     = count_r;
  assign out_max_rank = empty ? {RANK_BITS{1'b1}} : tail_rank;

  `BPRQ_ASSERT_SAME(a_fill_bound, 1'b1, count_r <= CNT_W'(DEPTH), "fill above depth")
  `BPRQ_ASSERT_NEXT(a_evict_keeps_fill, accept && ctl.push && evict, count_r == $past(count_r), "eviction changed fill")
  `BPRQ_ASSERT_NEXT(a_head_pop_drops_one, ctl.pop_head, count_r == $past(count_r) - CNT_W'(1), "head pop did not drop one entry")

endmodule
